// ----- design/cphm_pkg.sv -----
// Shared types, constants and register codes for the channel peak hold meter.
package cphm_pkg;

    // Default number of metered channels.
    localparam int CHANNELS_DEF = 8;

    // Field widths.
    localparam int CH_W    = 3;
    localparam int LVL_IN_W = 16;
    localparam int LVL_W   = 15;
    localparam int DECAY_W = 14;
    localparam int HOLD_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Level limits in hundredths of a dB.
    localparam logic signed [LVL_W-1:0] FLOOR_CDB = -15'sd10000;
    localparam logic signed [LVL_W-1:0] CLIP_CDB  = 15'sd0;
    localparam logic [HOLD_W-1:0] COUNTER_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_EN    = 2'd2;

    // Register reset values.
    localparam logic [DECAY_W-1:0] DECAY_RST = 14'd20;
    localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd100;

    // Item kinds carried on the input tuser.
    localparam logic MODE_LEVEL = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // One accepted input beat.
    typedef struct packed {
        logic                       mode;
        logic [CH_W-1:0]            channel;
        logic signed [LVL_IN_W-1:0] level;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic                    clip_lit;
        logic                    peak_visible;
        logic                    level_visible;
        logic signed [LVL_W-1:0] peak;
        logic signed [LVL_W-1:0] level;
        logic [CH_W-1:0]         channel;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [DECAY_W-1:0] decay_step;
        logic [HOLD_W-1:0]  clip_hold_frames;
        logic               clip_enable;
    } cfg_t;

endpackage

// ----- design/cphm_in_reg.sv -----
// Input register stage that holds one beat while the update stage is stalled.
module cphm_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cphm_pkg::item_t s_item,
    output logic            q_valid,
    input  logic            q_take,
    output cphm_pkg::item_t q_item
);
    import cphm_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept a new beat when empty or when the held beat moves on.
    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- design/cphm_update.sv -----
// Per-channel peak, seen and clip state with the single-pass update logic.
module cphm_update #(
    parameter int CHANNELS = cphm_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cphm_pkg::item_t   item,
    input  cphm_pkg::cfg_t    cfg,
    output cphm_pkg::result_t result
);
    import cphm_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [LVL_W-1:0]  peak_reg [CHANNELS];
    logic                     seen_reg [CHANNELS];
    logic                     clip_reg [CHANNELS];
    logic [HOLD_W-1:0]        cnt_reg  [CHANNELS];

    logic [6:0]               ch_wide;
    logic [IDX_W-1:0]         idx;
    logic                     hit;
    logic signed [LVL_W-1:0]  lvl;
    logic signed [LVL_W-1:0]  peak_cur;
    logic                     seen_cur;
    logic                     clip_cur;
    logic [HOLD_W-1:0]        cnt_cur;
    logic signed [16:0]       decayed;
    logic signed [16:0]       lvl_wide;
    logic signed [16:0]       raised;
    logic signed [LVL_W-1:0]  peak_next;
    logic                     clip_next;
    logic [HOLD_W-1:0]        cnt_next;
    logic [HOLD_W-1:0]        cnt_inc;

    // Channel decode; channels beyond the store touch no state.
    assign ch_wide = 7'(item.channel);
    assign idx     = ch_wide[IDX_W-1:0];
    assign hit     = ch_wide < 7'(CHANNELS);

    assign peak_cur = hit ? peak_reg[idx] : FLOOR_CDB;
    assign seen_cur = hit ? seen_reg[idx] : 1'b0;
    assign clip_cur = hit ? clip_reg[idx] : 1'b0;
    assign cnt_cur  = hit ? cnt_reg[idx]  : '0;

    // Clamp the level to the meter range; a clear shows the floor.
    always_comb begin
        priority if (item.mode == MODE_CLEAR) begin
            lvl = FLOOR_CDB;
        end else if (item.level < 16'(FLOOR_CDB)) begin
            lvl = FLOOR_CDB;
        end else if (item.level > 16'sd0) begin
            lvl = CLIP_CDB;
        end else begin
            lvl = item.level[LVL_W-1:0];
        end
    end

    // Decay the held peak, raise it to the level and floor it; a clear or first level sets it.
    assign decayed  = {{2{peak_cur[LVL_W-1]}}, peak_cur} - {3'b000, cfg.decay_step};
    assign lvl_wide = {{2{lvl[LVL_W-1]}}, lvl};
    assign raised   = (lvl_wide > decayed) ? lvl_wide : decayed;

    always_comb begin
        priority if (item.mode == MODE_CLEAR) begin
            peak_next = FLOOR_CDB;
        end else if (!seen_cur) begin
            peak_next = lvl;
        end else if (raised < 17'(FLOOR_CDB)) begin
            peak_next = FLOOR_CDB;
        end else begin
            peak_next = raised[LVL_W-1:0];
        end
    end

    // Clip flag and hold counter; the counter saturates.
    assign cnt_inc = (cnt_cur == COUNTER_MAX) ? cnt_cur : cnt_cur + 1'b1;

    always_comb begin
        clip_next = clip_cur;
        cnt_next  = cnt_cur;
        if (cfg.clip_enable) begin
            priority if (item.mode == MODE_CLEAR) begin
                clip_next = 1'b0;
                cnt_next  = '0;
            end else if (lvl >= CLIP_CDB) begin
                clip_next = 1'b1;
                cnt_next  = '0;
            end else if (clip_cur) begin
                cnt_next  = cnt_inc;
                clip_next = !(cnt_inc >= cfg.clip_hold_frames);
            end else begin
                clip_next = clip_cur;
            end
        end
    end

    // State write for the addressed channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                peak_reg[i] <= FLOOR_CDB;
                seen_reg[i] <= 1'b0;
                clip_reg[i] <= 1'b0;
                cnt_reg[i]  <= '0;
            end
        end else if (en && hit) begin
            peak_reg[idx] <= peak_next;
            seen_reg[idx] <= seen_cur || (item.mode == MODE_LEVEL);
            clip_reg[idx] <= clip_next;
            cnt_reg[idx]  <= cnt_next;
        end
    end

    // Result fields for this beat.
    always_comb begin
        result.channel       = item.channel;
        result.level         = lvl;
        result.peak          = hit ? peak_next : FLOOR_CDB;
        result.level_visible = lvl > FLOOR_CDB;
        result.peak_visible  = hit && (peak_next > FLOOR_CDB);
        result.clip_lit      = hit && clip_next;
    end

endmodule

// ----- design/channel_peak_hold_meter.sv -----
// Each accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls the output; a channel's state
// is read and written in the update stage, so consecutive beats on one channel need no wait.
// Reset (aresetn low, synchronous) empties both stages, sets all peaks to -100 dB,
// clears the seen and clip state and loads the register defaults 20, 100 and 1.
module channel_peak_hold_meter #(
    parameter int CHANNELS = cphm_pkg::CHANNELS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: channel [2:0], level_in [18:3], zero fill [23:19]
    input  logic [23:0]                        s_axis_tdata,
    // tuser: mode [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: channel_out [2:0], level_out [17:3], peak_out [32:18],
    // level_visible [33], peak_visible [34], clip_lit [35], zero fill [39:36]
    output logic [39:0]                        m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [cphm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cphm_pkg::CFG_W-1:0]         cfg_wdata
);
    import cphm_pkg::*;

    cfg_t    cfg_reg;
    item_t   s_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_take;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_load;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decay_step       <= DECAY_RST;
            cfg_reg.clip_hold_frames <= HOLD_RST;
            cfg_reg.clip_enable      <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DECAY_STEP: cfg_reg.decay_step       <= cfg_wdata[DECAY_W-1:0];
                REG_CLIP_HOLD:  cfg_reg.clip_hold_frames <= cfg_wdata[HOLD_W-1:0];
                REG_CLIP_EN:    cfg_reg.clip_enable      <= cfg_wdata[0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Unpack the input beat.
    assign s_item.mode    = s_axis_tuser;
    assign s_item.channel = s_axis_tdata[CH_W-1:0];
    assign s_item.level   = s_axis_tdata[CH_W+LVL_IN_W-1:CH_W];

    cphm_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    // The held beat updates state exactly when the result register takes it.
    assign out_load = !out_valid_reg || m_axis_tready;
    assign q_take   = q_valid && out_load;

    cphm_update #(
        .CHANNELS (CHANNELS)
    ) u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (q_take),
        .item    (q_item),
        .cfg     (cfg_reg),
        .result  (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_take) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_reg};

    // The input only stalls when both stages hold beats and the output waits.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (q_valid && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // Shown peak never leaves the meter range.
    a_peak_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res_reg.peak >= FLOOR_CDB && res_reg.peak <= CLIP_CDB))
        else $error("peak out of range");

    // Visibility flags agree with the values they describe.
    a_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((res_reg.peak_visible == (res_reg.peak != FLOOR_CDB))
                       && (res_reg.level_visible == (res_reg.level != FLOOR_CDB))))
        else $error("visibility flag mismatch");

endmodule
